### rtl/core/osst_pkg.sv
// Shared constants, codes and types for the order statistic slot tree.
`default_nettype none
package osst_pkg;

  localparam int MAX_SLOTS  = 1024;
  localparam int TREE_LG    = $clog2(MAX_SLOTS);
  localparam int NODE_AW    = TREE_LG + 1;
  localparam int NODE_COUNT = 2 * MAX_SLOTS;
  localparam int PTR_W      = NODE_AW + 1;
  localparam int DEPTH_W    = $clog2(TREE_LG + 1);

  localparam int REQ_W    = 2;
  localparam int SLOT_W   = 10;
  localparam int VALUE_W  = 8;
  localparam int TOTAL_W  = 18;
  localparam int STATUS_W = 2;
  localparam int SIZE_W   = 11;
  localparam int NODE_W   = TOTAL_W;

  localparam logic [REQ_W-1:0] REQ_SELECT = 2'd0;
  localparam logic [REQ_W-1:0] REQ_SET    = 2'd1;
  localparam logic [REQ_W-1:0] REQ_RANGE  = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
  localparam logic [STATUS_W-1:0] ST_RANK = 2'd1;
  localparam logic [STATUS_W-1:0] ST_BAD  = 2'd2;

  typedef struct packed {
    logic               we;
    logic [NODE_AW-1:0] addr;
    logic [NODE_W-1:0]  data;
    logic               last;
  } osst_fill_t;

endpackage
`default_nettype wire

### rtl/core/osst_in_if.sv
// Request channel: valid/ready handshake with the request payload.
`default_nettype none
interface osst_in_if import osst_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [REQ_W-1:0]    req_type;
  logic [SLOT_W-1:0]   rank;
  logic [SLOT_W-1:0]   slot_index;
  logic [VALUE_W-1:0]  slot_value;
  logic [SLOT_W-1:0]   range_low;
  logic [SLOT_W-1:0]   range_high;

  modport source (output valid, req_type, rank, slot_index, slot_value, range_low,
                  range_high, input ready);
  modport sink (input valid, req_type, rank, slot_index, slot_value, range_low,
                range_high, output ready);
endinterface
`default_nettype wire

### rtl/core/osst_out_if.sv
// Result channel: valid/ready handshake with the result payload.
`default_nettype none
interface osst_out_if import osst_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [SLOT_W-1:0]   found_slot;
  logic [TOTAL_W-1:0]  range_total;
  logic [STATUS_W-1:0] status;

  modport source (output valid, found_slot, range_total, status, input ready);
  modport sink (input valid, found_slot, range_total, status, output ready);
endinterface
`default_nettype wire

### rtl/core/osst_cfg_if.sv
// Configuration write channel carrying the active slot count.
`default_nettype none
interface osst_cfg_if import osst_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [SIZE_W-1:0] active_size;

  modport source (output valid, active_size, input ready);
  modport sink (input valid, active_size, output ready);
endinterface
`default_nettype wire

### rtl/core/osst_fill_gen.sv
// Tree rebuild sweep: one node write per cycle with the count of active leaves below it.
`default_nettype none
module osst_fill_gen import osst_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  input  wire logic [SIZE_W-1:0] size,
  output osst_fill_t             fill
);

  logic               active_r;
  logic [NODE_AW-1:0] addr_r;
  logic [SIZE_W-1:0]  base_r;
  logic [SIZE_W-1:0]  span_r;
  logic [SIZE_W-1:0]  base_sum;
  logic [SIZE_W-1:0]  remain;
  logic [SIZE_W-1:0]  value;
  logic               last;

  always_comb begin
    base_sum = base_r + span_r;
    remain   = size - base_r;
    if (size > base_r) begin
      value = (remain < span_r) ? remain : span_r;
    end else begin
      value = '0;
    end
    last       = active_r && (addr_r == NODE_AW'(NODE_COUNT - 1));
    fill.we    = active_r;
    fill.addr  = addr_r;
    fill.data  = NODE_W'(value);
    fill.last  = last;
  end

  // Walk nodes in heap order; each level spans the slot row once.
  always_ff @(posedge clk) begin
    if (!rst_n || start) begin
      active_r <= 1'b1;
      addr_r   <= NODE_AW'(1);
      base_r   <= '0;
      span_r   <= SIZE_W'(MAX_SLOTS);
    end else if (active_r) begin
      if (last) begin
        active_r <= 1'b0;
      end
      addr_r <= addr_r + NODE_AW'(1);
      if (base_sum == SIZE_W'(MAX_SLOTS)) begin
        base_r <= '0;
        span_r <= span_r >> 1;
      end else begin
        base_r <= base_sum;
      end
    end
  end

endmodule
`default_nettype wire

### rtl/core/order_statistic_slot_tree.sv
// Top level of the order statistic slot tree.
`default_nettype none
// Keeps a count per slot (1024 slots) in a binary sum tree held in a single-port
// 2048 x 18 node memory, and serves one request at a time: select the slot that
// holds the rank-th unit and clear it, overwrite one slot's count, or sum a slot
// range. Every request gives exactly one result unless a configuration write cuts
// it off. The memory does one access per cycle with registered read data, so each
// tree level takes a read state and a state using the data: select reads down the
// eleven levels and set reads up them, then both write back each sum on the path;
// an invalid one goes straight to the result, and a range sum's work depends on
// how many nodes it covers. After reset and after every write of active_size the
// tree is rebuilt by a sweep over nodes 1 to 2047, during which no request is
// taken; configuration writes are always taken and restart the sweep. A finished
// result sits in an output register, so the next request is taken while it waits.
module order_statistic_slot_tree import osst_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  osst_in_if.sink   in_ch,
  osst_out_if.source out_ch,
  osst_cfg_if.sink  cfg_ch
);

  typedef enum logic [3:0] {
    S_CLR, S_IDLE, S_ROOT_RD, S_ROOT_CHK, S_SEL_RD, S_SEL_CHK,
    S_SET_RD, S_SET_DAT, S_WR, S_RNG, S_RNG_DAT, S_DONE
  } state_t;

  state_t              state_r, state_nxt;
  logic [SIZE_W-1:0]   n_r, n_nxt;
  logic [REQ_W-1:0]    req_r, req_nxt;
  logic [SLOT_W-1:0]   k_r, k_nxt;
  logic [SLOT_W-1:0]   slot_r, slot_nxt;
  logic [VALUE_W-1:0]  newleaf_r, newleaf_nxt;
  logic [NODE_AW-1:0]  v_r, v_nxt;
  logic [DEPTH_W-1:0]  depth_r, depth_nxt;
  logic [NODE_W-1:0]   cur_r, cur_nxt;
  logic [NODE_W-1:0]   path_r [0:TREE_LG];
  logic [NODE_W-1:0]   path_nxt [0:TREE_LG];
  logic [PTR_W-1:0]    l_r, l_nxt, r_r, r_nxt;
  logic [NODE_W-1:0]   acc_r, acc_nxt;
  logic [STATUS_W-1:0] status_r, status_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [SLOT_W-1:0]   out_slot_r, out_slot_nxt;
  logic [TOTAL_W-1:0]  out_total_r, out_total_nxt;
  logic [STATUS_W-1:0] out_status_r, out_status_nxt;

  logic [NODE_W-1:0]   node_mem [0:NODE_COUNT-1];
  logic [NODE_W-1:0]   rd_data_r;
  logic [NODE_AW-1:0]  mem_addr;
  logic                mem_we;
  logic [NODE_W-1:0]   mem_wdata;

  logic [DEPTH_W-1:0]  depth_inc;
  logic [NODE_AW-1:0]  child;
  logic [NODE_W-1:0]   sel_sum;
  logic [PTR_W-1:0]    r_dec;
  logic [SIZE_W-1:0]   cfg_size;
  osst_fill_t          fill;

  osst_fill_gen u_fill (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cfg_ch.valid),
    .size  (n_r),
    .fill  (fill)
  );

  assign in_ch.ready        = (state_r == S_IDLE);
  assign cfg_ch.ready       = 1'b1;
  assign out_ch.valid       = out_valid_r;
  assign out_ch.found_slot  = out_slot_r;
  assign out_ch.range_total = out_total_r;
  assign out_ch.status      = out_status_r;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      node_mem[mem_addr] <= mem_wdata;
    end
    rd_data_r <= node_mem[mem_addr];
  end

  always_comb begin
    if (cfg_ch.active_size == '0) begin
      cfg_size = SIZE_W'(1);
    end else if (cfg_ch.active_size > SIZE_W'(MAX_SLOTS)) begin
      cfg_size = SIZE_W'(MAX_SLOTS);
    end else begin
      cfg_size = cfg_ch.active_size;
    end
  end

  always_comb begin
    state_nxt      = state_r;
    n_nxt          = n_r;
    req_nxt        = req_r;
    k_nxt          = k_r;
    slot_nxt       = slot_r;
    newleaf_nxt    = newleaf_r;
    v_nxt          = v_r;
    depth_nxt      = depth_r;
    cur_nxt        = cur_r;
    path_nxt       = path_r;
    l_nxt          = l_r;
    r_nxt          = r_r;
    acc_nxt        = acc_r;
    status_nxt     = status_r;
    out_valid_nxt  = out_valid_r;
    out_slot_nxt   = out_slot_r;
    out_total_nxt  = out_total_r;
    out_status_nxt = out_status_r;
    mem_addr       = '0;
    mem_we         = 1'b0;
    mem_wdata      = '0;
    depth_inc      = depth_r + DEPTH_W'(1);
    child          = '0;
    sel_sum        = '0;
    r_dec          = r_r - PTR_W'(1);

    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_CLR: begin
        mem_we    = fill.we;
        mem_addr  = fill.addr;
        mem_wdata = fill.data;
        if (fill.last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_ch.valid) begin
          req_nxt     = in_ch.req_type;
          k_nxt       = in_ch.rank;
          slot_nxt    = '0;
          newleaf_nxt = in_ch.slot_value;
          acc_nxt     = '0;
          status_nxt  = ST_OK;
          case (in_ch.req_type)
            REQ_SELECT: begin
              state_nxt = S_ROOT_RD;
            end
            REQ_SET: begin
              if (SIZE_W'(in_ch.slot_index) >= n_r) begin
                status_nxt = ST_BAD;
                state_nxt  = S_DONE;
              end else begin
                slot_nxt  = in_ch.slot_index;
                v_nxt     = NODE_AW'(MAX_SLOTS) + NODE_AW'(in_ch.slot_index);
                depth_nxt = DEPTH_W'(TREE_LG);
                state_nxt = S_SET_RD;
              end
            end
            REQ_RANGE: begin
              if (in_ch.range_low > in_ch.range_high ||
                  SIZE_W'(in_ch.range_high) >= n_r) begin
                status_nxt = ST_BAD;
                state_nxt  = S_DONE;
              end else begin
                l_nxt     = PTR_W'(MAX_SLOTS) + PTR_W'(in_ch.range_low);
                r_nxt     = PTR_W'(MAX_SLOTS) + PTR_W'(in_ch.range_high) + PTR_W'(1);
                state_nxt = S_RNG;
              end
            end
            default: begin
              status_nxt = ST_BAD;
              state_nxt  = S_DONE;
            end
          endcase
        end
      end
      S_ROOT_RD: begin
        mem_addr  = NODE_AW'(1);
        state_nxt = S_ROOT_CHK;
      end
      S_ROOT_CHK: begin
        if (rd_data_r <= NODE_W'(k_r)) begin
          status_nxt = ST_RANK;
          state_nxt  = S_DONE;
        end else begin
          path_nxt[0] = rd_data_r;
          cur_nxt     = rd_data_r;
          v_nxt       = NODE_AW'(1);
          depth_nxt   = '0;
          state_nxt   = S_SEL_RD;
        end
      end
      S_SEL_RD: begin
        mem_addr  = {v_r[NODE_AW-2:0], 1'b0};
        state_nxt = S_SEL_CHK;
      end
      S_SEL_CHK: begin
        // Left child sum decides the branch; going right skips its units.
        if (rd_data_r > NODE_W'(k_r)) begin
          child   = {v_r[NODE_AW-2:0], 1'b0};
          sel_sum = rd_data_r;
        end else begin
          child   = {v_r[NODE_AW-2:0], 1'b1};
          sel_sum = cur_r - rd_data_r;
          k_nxt   = k_r - SLOT_W'(rd_data_r);
        end
        path_nxt[depth_inc] = sel_sum;
        cur_nxt             = sel_sum;
        v_nxt               = child;
        depth_nxt           = depth_inc;
        if (depth_inc == DEPTH_W'(TREE_LG)) begin
          slot_nxt    = child[SLOT_W-1:0];
          newleaf_nxt = '0;
          state_nxt   = S_WR;
        end else begin
          state_nxt = S_SEL_RD;
        end
      end
      S_SET_RD: begin
        mem_addr  = v_r;
        state_nxt = S_SET_DAT;
      end
      S_SET_DAT: begin
        path_nxt[depth_r] = rd_data_r;
        if (depth_r == '0) begin
          v_nxt     = NODE_AW'(MAX_SLOTS) + NODE_AW'(slot_r);
          depth_nxt = DEPTH_W'(TREE_LG);
          state_nxt = S_WR;
        end else begin
          v_nxt     = v_r >> 1;
          depth_nxt = depth_r - DEPTH_W'(1);
          state_nxt = S_SET_RD;
        end
      end
      S_WR: begin
        // Shift every sum on the path by the change of the leaf.
        mem_we    = 1'b1;
        mem_addr  = v_r;
        mem_wdata = path_r[depth_r] - path_r[TREE_LG] + NODE_W'(newleaf_r);
        if (depth_r == '0) begin
          state_nxt = S_DONE;
        end else begin
          v_nxt     = v_r >> 1;
          depth_nxt = depth_r - DEPTH_W'(1);
        end
      end
      S_RNG: begin
        if (l_r >= r_r) begin
          state_nxt = S_DONE;
        end else if (l_r[0]) begin
          mem_addr  = l_r[NODE_AW-1:0];
          l_nxt     = l_r + PTR_W'(1);
          state_nxt = S_RNG_DAT;
        end else if (r_r[0]) begin
          mem_addr  = r_dec[NODE_AW-1:0];
          r_nxt     = r_dec;
          state_nxt = S_RNG_DAT;
        end else begin
          l_nxt = l_r >> 1;
          r_nxt = r_r >> 1;
        end
      end
      S_RNG_DAT: begin
        acc_nxt   = acc_r + rd_data_r;
        state_nxt = S_RNG;
      end
      S_DONE: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt  = 1'b1;
          out_slot_nxt   = (status_r == ST_OK && req_r == REQ_SELECT) ? slot_r : '0;
          out_total_nxt  = acc_r;
          out_status_nxt = status_r;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (cfg_ch.valid) begin
      n_nxt     = cfg_size;
      state_nxt = S_CLR;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      n_r         <= SIZE_W'(MAX_SLOTS);
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      n_r         <= n_nxt;
      out_valid_r <= out_valid_nxt;
    end
    req_r        <= req_nxt;
    k_r          <= k_nxt;
    slot_r       <= slot_nxt;
    newleaf_r    <= newleaf_nxt;
    v_r          <= v_nxt;
    depth_r      <= depth_nxt;
    cur_r        <= cur_nxt;
    path_r       <= path_nxt;
    l_r          <= l_nxt;
    r_r          <= r_nxt;
    acc_r        <= acc_nxt;
    status_r     <= status_nxt;
    out_slot_r   <= out_slot_nxt;
    out_total_r  <= out_total_nxt;
    out_status_r <= out_status_nxt;
  end

endmodule
`default_nettype wire

### rtl/core/osst_checker.sv
// Port-level checks for the order statistic slot tree, bound to the top level.
`default_nettype none
module osst_checker import osst_pkg::*; (
  input wire logic                clk,
  input wire logic                rst_n,
  input wire logic                in_valid,
  input wire logic                in_ready,
  input wire logic                out_valid,
  input wire logic                out_ready,
  input wire logic [SLOT_W-1:0]   found_slot,
  input wire logic [TOTAL_W-1:0]  range_total,
  input wire logic [STATUS_W-1:0] status
);

  // Requests are served one at a time.
  a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request taken while a request is in work");

  a_fail_fields_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && status != ST_OK |-> found_slot == '0 && range_total == '0)
    else $error("failed request carries a slot or total");

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_ready)
    else $error("result or ready shown right after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(found_slot) &&
      $stable(range_total) && $stable(status))
    else $error("stalled result dropped or changed");

endmodule

bind order_statistic_slot_tree osst_checker u_osst_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_ch.valid),
  .in_ready    (in_ch.ready),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .found_slot  (out_ch.found_slot),
  .range_total (out_ch.range_total),
  .status      (out_ch.status)
);
`default_nettype wire

### bench/order_statistic_slot_tree_tb.sv
// Self-checking testbench for the order statistic slot tree against a slot-count model.
`timescale 1ns / 100ps
module order_statistic_slot_tree_tb;
  import osst_pkg::*;

  localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;
  localparam int IDLE_PCT    = 12;
  localparam int BATCH       = 66;
  localparam int SETTLE      = 40;
  localparam int QUIET_LIMIT = 20000;
  localparam int HOLD_AT     = 200;
  localparam int HOLD_LEN    = 500;

  typedef struct {
    logic [REQ_W-1:0]   req_type;
    logic [SLOT_W-1:0]  rank;
    logic [SLOT_W-1:0]  slot_index;
    logic [VALUE_W-1:0] slot_value;
    logic [SLOT_W-1:0]  range_low;
    logic [SLOT_W-1:0]  range_high;
  } request_t;

  typedef struct {
    logic [SLOT_W-1:0]   found_slot;
    logic [TOTAL_W-1:0]  range_total;
    logic [STATUS_W-1:0] status;
  } answer_t;

  logic clk;
  logic rst_n;

  osst_in_if  in_ch ();
  osst_out_if out_ch ();
  osst_cfg_if cfg_ch ();

  order_statistic_slot_tree u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  // Flat per-slot counts; the tree sums are implied by them.
  int unsigned slot_counts [MAX_SLOTS];
  int          active_slots;

  request_t queued_requests [$];
  answer_t  awaited_answers [$];
  request_t on_offer;
  int       requests_issued;
  int       answers_seen;
  int       err_count;
  int       stall_left;
  bit       steady;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    err_count++;
    if (err_count <= 100)
      $display("%0t mismatch %s: got %0d, want %0d", $time, what, got, want);
  endtask

  function automatic void resize_model(input logic [SIZE_W-1:0] v);
    int n;
    n = int'(v);
    if (n < 1) n = 1;
    if (n > MAX_SLOTS) n = MAX_SLOTS;
    active_slots = n;
    for (int i = 0; i < MAX_SLOTS; i++) slot_counts[i] = (i < n) ? 1 : 0;
  endfunction

  function automatic answer_t answer_request(input request_t r);
    answer_t     a;
    int unsigned total;
    int unsigned run;
    int          s;
    a.found_slot  = '0;
    a.range_total = '0;
    a.status      = ST_OK;
    total = 0;
    case (r.req_type)
      REQ_SELECT: begin
        for (s = 0; s < active_slots; s++) total += slot_counts[s];
        if (r.rank >= total) begin
          a.status = ST_RANK;
        end else begin
          // walk the units slot by slot until the rank-th one is covered
          s = 0;
          run = slot_counts[0];
          while (run <= r.rank) begin
            s++;
            run += slot_counts[s];
          end
          a.found_slot = SLOT_W'(s);
          slot_counts[s] = 0;
        end
      end
      REQ_SET: begin
        if (r.slot_index >= active_slots) a.status = ST_BAD;
        else slot_counts[r.slot_index] = 32'(r.slot_value);
      end
      REQ_RANGE: begin
        if (r.range_low > r.range_high || r.range_high >= active_slots) begin
          a.status = ST_BAD;
        end else begin
          for (s = int'(r.range_low); s <= r.range_high; s++) total += slot_counts[s];
          a.range_total = TOTAL_W'(total);
        end
      end
      default: a.status = ST_BAD;
    endcase
    return a;
  endfunction

  task automatic queue_request(input logic [REQ_W-1:0] kind, input int rank, input int idx,
                               input int val, input int lo, input int hi);
    request_t r;
    r.req_type   = kind;
    r.rank       = SLOT_W'(rank);
    r.slot_index = SLOT_W'(idx);
    r.slot_value = VALUE_W'(val);
    r.range_low  = SLOT_W'(lo);
    r.range_high = SLOT_W'(hi);
    queued_requests.push_back(r);
  endtask

  function automatic request_t random_request(input int slots);
    request_t r;
    int       pick;
    int       top;
    top = (slots > 1023) ? 1023 : slots;
    r.req_type   = REQ_W'($urandom);
    r.rank       = SLOT_W'($urandom);
    r.slot_index = SLOT_W'($urandom);
    r.slot_value = VALUE_W'($urandom);
    r.range_low  = SLOT_W'($urandom);
    r.range_high = SLOT_W'($urandom);
    pick = $urandom_range(99, 0);
    if (pick < 36) begin
      r.req_type = REQ_SELECT;
      if ($urandom_range(9, 0) < 8) r.rank = SLOT_W'($urandom_range(top, 0));
    end else if (pick < 66) begin
      r.req_type = REQ_SET;
      if ($urandom_range(9, 0) < 9) r.slot_index = SLOT_W'($urandom_range(slots - 1, 0));
      case ($urandom_range(4, 0))
        0: r.slot_value = '0;
        1: r.slot_value = '1;
        default: ;
      endcase
    end else if (pick < 95) begin
      r.req_type = REQ_RANGE;
      if ($urandom_range(19, 0) == 0) begin
        r.range_low  = '0;
        r.range_high = SLOT_W'(slots - 1);
      end else if ($urandom_range(19, 0) < 17) begin
        r.range_low  = SLOT_W'($urandom_range(slots - 1, 0));
        r.range_high = SLOT_W'($urandom_range(slots - 1, r.range_low));
      end
    end else begin
      r.req_type = REQ_UNUSED;
    end
    return r;
  endfunction

  task automatic queue_random(input int count, input int slots);
    for (int i = 0; i < count; i++) queued_requests.push_back(random_request(slots));
  endtask

  // Hold the sender until every transfer has its answer back.
  task automatic wait_idle();
    do @(posedge clk);
    while (queued_requests.size() != 0 || answers_seen < requests_issued);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_size(input logic [SIZE_W-1:0] v);
    cfg_ch.active_size <= v;
    cfg_ch.valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
    resize_model(v);
  endtask

  // Request driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) awaited_answers.push_back(answer_request(on_offer));
      if (!in_ch.valid || in_ch.ready) begin
        if (queued_requests.size() != 0 && (steady || $urandom_range(99, 0) >= IDLE_PCT)) begin
          on_offer = queued_requests.pop_front();
          requests_issued++;
          in_ch.valid      <= 1'b1;
          in_ch.req_type   <= on_offer.req_type;
          in_ch.rank       <= on_offer.rank;
          in_ch.slot_index <= on_offer.slot_index;
          in_ch.slot_value <= on_offer.slot_value;
          in_ch.range_low  <= on_offer.range_low;
          in_ch.range_high <= on_offer.range_high;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor
  always @(posedge clk) begin : result_monitor
    answer_t want;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        answers_seen++;
        if (awaited_answers.size() == 0) begin
          report_mismatch("result with no request", 32'(out_ch.status), 0);
        end else begin
          want = awaited_answers.pop_front();
          if (out_ch.found_slot !== want.found_slot)
            report_mismatch("found_slot", 32'(out_ch.found_slot), 32'(want.found_slot));
          if (out_ch.range_total !== want.range_total)
            report_mismatch("range_total", 32'(out_ch.range_total),
                            32'(want.range_total));
          if (out_ch.status !== want.status)
            report_mismatch("status", 32'(out_ch.status), 32'(want.status));
        end
        // back up the block once while the sender keeps offering
        if (answers_seen == HOLD_AT) stall_left = HOLD_LEN;
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= steady || ($urandom_range(99, 0) >= IDLE_PCT);
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
          (cfg_ch.valid && cfg_ch.ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("order_statistic_slot_tree_tb: errors");
    $finish;
  end

  initial begin : main_seq
    logic [SIZE_W-1:0] sizes [8];
    int                slots;
    rst_n              = 1'b0;
    in_ch.valid        = 1'b0;
    in_ch.req_type     = '0;
    in_ch.rank         = '0;
    in_ch.slot_index   = '0;
    in_ch.slot_value   = '0;
    in_ch.range_low    = '0;
    in_ch.range_high   = '0;
    out_ch.ready       = 1'b0;
    cfg_ch.valid       = 1'b0;
    cfg_ch.active_size = '0;
    steady             = 1'b0;
    stall_left         = 0;
    err_count          = 0;
    requests_issued    = 0;
    answers_seen       = 0;
    resize_model(SIZE_W'(MAX_SLOTS));
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Full tree after reset: edges of ranges, select at both ends, overflow rank.
    queue_request(REQ_RANGE, 0, 0, 0, 0, 1023);
    queue_request(REQ_RANGE, 0, 0, 0, 0, 0);
    queue_request(REQ_RANGE, 0, 0, 0, 1023, 1023);
    queue_request(REQ_RANGE, 0, 0, 0, 6, 5);
    queue_request(REQ_SELECT, 0, 0, 0, 0, 0);
    queue_request(REQ_SELECT, 0, 0, 0, 0, 0);
    queue_request(REQ_SELECT, 1021, 0, 0, 0, 0);
    queue_request(REQ_SELECT, 1021, 0, 0, 0, 0);
    queue_request(REQ_SELECT, 1023, 0, 0, 0, 0);
    queue_request(REQ_SET, 0, 1023, 255, 0, 0);
    queue_request(REQ_SET, 0, 0, 255, 0, 0);
    queue_request(REQ_SET, 0, 512, 0, 0, 0);
    queue_request(REQ_RANGE, 0, 0, 0, 0, 1023);
    queue_request(REQ_SELECT, 1023, 0, 0, 0, 0);
    queue_request(REQ_SET, 0, 7, 0, 0, 0);
    queue_request(REQ_UNUSED, 1023, 1023, 255, 1023, 1023);
    queue_request(REQ_UNUSED, 0, 0, 0, 0, 0);
    queue_request(REQ_RANGE, 0, 0, 0, 0, 1023);
    queue_request(REQ_SELECT, 0, 0, 0, 0, 0);
    wait_idle();
    queue_random(BATCH, MAX_SLOTS);
    wait_idle();
    queue_random(BATCH, MAX_SLOTS);
    wait_idle();

    // Two slots: out-of-range index and range, rank past the total, empty tree.
    write_size(SIZE_W'(2));
    queue_request(REQ_SET, 0, 2, 9, 0, 0);
    queue_request(REQ_SET, 0, 1023, 9, 0, 0);
    queue_request(REQ_RANGE, 0, 0, 0, 0, 2);
    queue_request(REQ_RANGE, 0, 0, 0, 0, 1);
    queue_request(REQ_SELECT, 2, 0, 0, 0, 0);
    queue_request(REQ_SELECT, 1, 0, 0, 0, 0);
    queue_request(REQ_SELECT, 0, 0, 0, 0, 0);
    queue_request(REQ_SELECT, 0, 0, 0, 0, 0);
    queue_request(REQ_RANGE, 0, 0, 0, 1, 1);
    queue_random(BATCH, 2);
    wait_idle();
    queue_random(BATCH, 2);
    wait_idle();

    sizes[0] = SIZE_W'(0);
    sizes[1] = SIZE_W'(2047);
    sizes[2] = SIZE_W'(1);
    sizes[3] = SIZE_W'(1024);
    sizes[4] = SIZE_W'(513);
    sizes[5] = SIZE_W'(3);
    sizes[6] = SIZE_W'($urandom_range(1022, 4));
    sizes[7] = SIZE_W'(1025);
    for (int p = 0; p < 8; p++) begin
      slots = int'(sizes[p]);
      if (slots < 1) slots = 1;
      if (slots > MAX_SLOTS) slots = MAX_SLOTS;
      steady = (p == 1);
      write_size(sizes[p]);
      queue_random(BATCH, slots);
      wait_idle();
      queue_random(BATCH, slots);
      wait_idle();
    end
    steady = 1'b0;

    repeat (60) @(posedge clk);
    if (awaited_answers.size() != 0)
      report_mismatch("results never delivered", 32'(awaited_answers.size()), 0);
    if (err_count == 0)
      $display("order_statistic_slot_tree_tb: clean");
    else
      $display("order_statistic_slot_tree_tb: errors");
    $finish;
  end

endmodule

### order_statistic_slot_tree.f
rtl/core/osst_pkg.sv
rtl/core/osst_in_if.sv
rtl/core/osst_out_if.sv
rtl/core/osst_cfg_if.sv
rtl/core/osst_fill_gen.sv
rtl/core/order_statistic_slot_tree.sv
rtl/core/osst_checker.sv
bench/order_statistic_slot_tree_tb.sv
